>>> rtl/per_client_rate_limiter_core_assert.svh
// assertion macros used by the rate limiter controller
// the module that uses them has clk and arst_n in scope
`ifndef PER_CLIENT_RATE_LIMITER_CORE_ASSERT_SVH
`define PER_CLIENT_RATE_LIMITER_CORE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define PCRL_ASSERT_SAME(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
else $error(msg);

// condition holds in the cycle after the trigger
`define PCRL_ASSERT_NEXT(name, ante, cons, msg) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

>>> rtl/pcrl_pkg.sv
package pcrl_pkg;

	localparam int CLIENT_SLOTS = 8;
	localparam int SLOT_W = (CLIENT_SLOTS > 1) ? $clog2(CLIENT_SLOTS) : 1;
	localparam int ADDR_W = 32;
	localparam int TIME_W = 32;
	localparam int COUNT_W = 16;
	localparam int CFG_W = 32;

	typedef logic [SLOT_W-1:0] slot_idx_t;
	typedef logic [CLIENT_SLOTS-1:0] slot_vec_t;

	// configuration register indexes
	typedef enum logic {
		CFG_MAX_REQUESTS  = 1'b0,
		CFG_WINDOW_LENGTH = 1'b1
	} cfg_idx_t;

	localparam logic [COUNT_W-1:0] MAX_REQUESTS_RST = 16'd60;
	localparam logic [TIME_W-1:0] WINDOW_LENGTH_RST = 32'd60000;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pick;
		logic age;
		logic commit;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
		logic in_clear;
	} dp_status_t;

	// lowest set bit, zero when none
	function automatic slot_idx_t first_set(slot_vec_t v);
		slot_idx_t idx;
		idx = '0;
		for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = SLOT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

>>> rtl/pcrl_req_if.sv
interface pcrl_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [31:0] client_address;
	logic [31:0] now_ms;

	modport source (output valid, output command, output client_address, output now_ms,
		input ready);
	modport sink (input valid, input command, input client_address, input now_ms,
		output ready);
endinterface

>>> rtl/pcrl_resp_if.sv
interface pcrl_resp_if;
	logic valid;
	logic ready;
	logic allowed;

	modport source (output valid, output allowed, input ready);
	modport sink (input valid, input allowed, output ready);
endinterface

>>> rtl/per_client_rate_limiter_core.sv
// per-client fixed window rate limiter
// req channel: one beat per request, command 0 checks client_address at time
//   now_ms, command 1 empties the whole client table
// resp channel: exactly one beat per req beat, in order; allowed is 1 when the
//   request is admitted, 0 when refused and always 0 for a clear
// cfg port: write max_requests (index 0) and window_length_ms (index 1) only
//   while no request is in flight
// sequence: a check beat is accepted, then slot pick, window aging and commit
//   follow, and commit loads its resp beat into the output register; a clear
//   goes from acceptance straight to commit
// occupancy: one request at a time, taken only while the sequencer is idle,
//   as a check does a single read-modify-write of a slot in the table registers
// reset: table empty, max_requests 60, window_length_ms 60000, no resp beat
// stall: the result sits in an output register; the next request is taken
//   while it waits, and holds at commit until the register frees up
module per_client_rate_limiter_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  pcrl_pkg::cfg_idx_t         cfg_index,
	input  logic [pcrl_pkg::CFG_W-1:0] cfg_data,
	pcrl_req_if.sink                   req,
	pcrl_resp_if.source                resp
);
	import pcrl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	// sequencer: idle, pick, age, commit
	pcrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// slot table, config registers and result register
	pcrl_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_command  (req.command),
		.in_address  (req.client_address),
		.in_now      (req.now_ms),
		.out_valid   (resp.valid),
		.out_ready   (resp.ready),
		.out_allowed (resp.allowed),
		.cmd         (cmd),
		.status      (status)
	);

endmodule

>>> rtl/pcrl_ctrl.sv
`include "per_client_rate_limiter_core_assert.svh"

module pcrl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pcrl_pkg::dp_status_t status,
	output pcrl_pkg::dp_cmd_t    cmd
);
	import pcrl_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_PICK   = 4'b0010,
		S_AGE    = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	assign cmd.load   = accept;
	assign cmd.pick   = (state_q == S_PICK);
	assign cmd.age    = (state_q == S_AGE);
	assign cmd.commit = (state_q == S_COMMIT) && status.out_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				// clear needs no lookup
				if (accept) begin
					state_d = status.in_clear ? S_COMMIT : S_PICK;
				end
			end
			S_PICK: begin
				state_d = S_AGE;
			end
			S_AGE: begin
				state_d = S_COMMIT;
			end
			S_COMMIT: begin
				if (status.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`PCRL_ASSERT_NEXT(a_check_goes_pick, accept && !status.in_clear, state_q == S_PICK,
		"check beat did not enter lookup")
	`PCRL_ASSERT_NEXT(a_clear_goes_commit, accept && status.in_clear, state_q == S_COMMIT,
		"clear beat did not go to commit")
	`PCRL_ASSERT_SAME(a_commit_needs_space, cmd.commit, status.out_free && !in_ready,
		"commit while output register busy")

endmodule

>>> rtl/pcrl_datapath.sv
module pcrl_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  pcrl_pkg::cfg_idx_t            cfg_index,
	input  logic [pcrl_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_command,
	input  logic [pcrl_pkg::ADDR_W-1:0]   in_address,
	input  logic [pcrl_pkg::TIME_W-1:0]   in_now,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_allowed,
	input  pcrl_pkg::dp_cmd_t             cmd,
	output pcrl_pkg::dp_status_t          status
);
	import pcrl_pkg::*;

	// configuration
	logic [COUNT_W-1:0] max_requests_q;
	logic [TIME_W-1:0]  window_length_q;

	// client table
	logic [ADDR_W-1:0]  slot_address_q [CLIENT_SLOTS];
	logic [TIME_W-1:0]  slot_start_q   [CLIENT_SLOTS];
	logic [COUNT_W-1:0] slot_count_q   [CLIENT_SLOTS];

	// item in flight
	logic               clear_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [TIME_W-1:0]  now_q;
	slot_vec_t          match_q;
	slot_vec_t          free_q;
	slot_idx_t          sel_q;
	logic [TIME_W-1:0]  start_q;
	logic [COUNT_W-1:0] count_q;

	// output register
	logic out_valid_q;
	logic allowed_q;

	slot_vec_t          match_d;
	slot_vec_t          free_d;
	slot_idx_t          sel_d;
	logic               hit;
	logic               expired;
	logic               allow;
	logic [TIME_W-1:0]  age;

	assign status.out_free = !out_valid_q || out_ready;
	assign status.in_clear = in_command;
	assign out_valid       = out_valid_q;
	assign out_allowed     = allowed_q;

	// parallel tag compare against the incoming address
	always_comb begin
		for (int i = 0; i < CLIENT_SLOTS; i++) begin
			free_d[i]  = (slot_start_q[i] == '0);
			match_d[i] = !free_d[i] && (slot_address_q[i] == in_address);
		end
	end

	assign hit   = |match_q;
	assign sel_d = hit ? first_set(match_q) : ((|free_q) ? first_set(free_q) : '0);

	// wrapping age of the window
	assign age     = now_q - start_q;
	assign expired = age > window_length_q;
	assign allow   = count_q < max_requests_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_requests_q  <= MAX_REQUESTS_RST;
			window_length_q <= WINDOW_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MAX_REQUESTS:  max_requests_q  <= cfg_data[COUNT_W-1:0];
				CFG_WINDOW_LENGTH: window_length_q <= cfg_data[TIME_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clear_q <= in_command;
			addr_q  <= in_address;
			now_q   <= in_now;
			match_q <= match_d;
			free_q  <= free_d;
		end
		if (cmd.pick) begin
			sel_q   <= sel_d;
			start_q <= hit ? slot_start_q[sel_d] : now_q;
			count_q <= hit ? slot_count_q[sel_d] : '0;
		end
		if (cmd.age && expired) begin
			start_q <= now_q;
			count_q <= '0;
		end
		if (cmd.commit) begin
			allowed_q <= !clear_q && allow;
		end
	end

	// window start doubles as the in-use flag, so it is reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLIENT_SLOTS; i++) begin
				slot_start_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			if (clear_q) begin
				for (int i = 0; i < CLIENT_SLOTS; i++) begin
					slot_start_q[i] <= '0;
				end
			end else begin
				slot_start_q[sel_q] <= start_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && !clear_q) begin
			slot_address_q[sel_q] <= addr_q;
			slot_count_q[sel_q]   <= allow ? count_q + 1'b1 : count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> dv/tb_per_client_rate_limiter_core.sv
`timescale 1ns / 1ps

module tb_per_client_rate_limiter_core;
	import pcrl_pkg::*;

	// command codes of a request beat
	localparam bit CMD_CHECK = 1'b0;
	localparam bit CMD_CLEAR = 1'b1;

	// the watchdog gives up after this many clock cycles
	localparam int unsigned CYCLE_LIMIT = 200000;
	// cycles to let the pipeline settle once the last resp beat is in
	localparam int SETTLE_CYCLES = 6;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int POOL_MAX = 12;
	localparam int DIRECTED_ROWS = 30;
	// length of the long receiver hold-off
	localparam int HOLD_OFF_CYCLES = 400;

	// what a directed row does, and how its verdict is obtained
	typedef enum {ROW_CHECK, ROW_CLEAR, ROW_SET_MAX, ROW_SET_WINDOW} row_kind_t;
	typedef enum {EXP_PREDICTED, EXP_REFUSED, EXP_ADMITTED} verdict_src_t;

	// stamp carries the register value on the register rows
	typedef struct {
		row_kind_t         kind;
		logic [ADDR_W-1:0] client;
		logic [TIME_W-1:0] stamp;
		verdict_src_t      verdict;
	} row_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	cfg_idx_t            cfg_index;
	logic [CFG_W-1:0]    cfg_data;

	pcrl_req_if  req();
	pcrl_resp_if resp();

	per_client_rate_limiter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.resp      (resp)
	);

	// shadow of the client table and the two limits
	logic [ADDR_W-1:0]  slot_client [CLIENT_SLOTS];
	logic [TIME_W-1:0]  slot_opened [CLIENT_SLOTS];
	logic [COUNT_W-1:0] slot_hits [CLIENT_SLOTS];
	logic [COUNT_W-1:0] lim_requests;
	logic [TIME_W-1:0]  lim_window;

	// verdicts of accepted request beats still waiting for their resp beat
	bit pending_verdicts [$];
	int mismatch_count;

	// idling controls shared between the stimulus and the receiver
	bit no_idle;
	bit hold_pending;
	int hold_left;

	int unsigned cycle_count;

	// directed stimulus, run at the reset settings unless a row changes them
	row_t directed_rows [DIRECTED_ROWS] = '{
		// first beats after reset are admitted
		'{ROW_CHECK, 32'h0A00_0001, 32'd1000, EXP_ADMITTED},
		'{ROW_CHECK, 32'h0A00_0001, 32'd1001, EXP_ADMITTED},
		// clear always answers refused
		'{ROW_CLEAR, 32'h0000_0000, 32'd0, EXP_REFUSED},
		// all-ones address and time
		'{ROW_CHECK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_ADMITTED},
		// time zero: the slot stays free, but this beat is still admitted
		'{ROW_CHECK, 32'h0000_0000, 32'd0, EXP_ADMITTED},
		'{ROW_CHECK, 32'h0000_0000, 32'd0, EXP_PREDICTED},
		// fill the table, then push two more clients, each evicting slot 0
		'{ROW_CHECK, 32'hC0A8_0001, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0002, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0003, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0004, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0005, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0006, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0007, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0008, 32'd5000, EXP_PREDICTED},
		'{ROW_CHECK, 32'hC0A8_0009, 32'd5001, EXP_PREDICTED},
		// window just past its length restarts the count
		'{ROW_CHECK, 32'hC0A8_0002, 32'd65002, EXP_PREDICTED},
		// time wraps through zero inside one window
		'{ROW_CHECK, 32'h7F00_0001, 32'hFFFF_FF00, EXP_PREDICTED},
		'{ROW_CHECK, 32'h7F00_0001, 32'h0000_0100, EXP_PREDICTED},
		// a limit of zero refuses everything
		'{ROW_SET_MAX, 32'h0, 32'd0, EXP_PREDICTED},
		'{ROW_CHECK, 32'h7F00_0001, 32'h0000_0200, EXP_REFUSED},
		// limit of two in an endless window: third beat is refused
		'{ROW_SET_MAX, 32'h0, 32'd2, EXP_PREDICTED},
		'{ROW_SET_WINDOW, 32'h0, 32'hFFFF_FFFF, EXP_PREDICTED},
		'{ROW_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, EXP_REFUSED},
		'{ROW_CHECK, 32'h0102_0304, 32'd7, EXP_ADMITTED},
		'{ROW_CHECK, 32'h0102_0304, 32'd8, EXP_ADMITTED},
		'{ROW_CHECK, 32'h0102_0304, 32'd9, EXP_REFUSED},
		// zero window and the largest limit
		'{ROW_SET_WINDOW, 32'h0, 32'd0, EXP_PREDICTED},
		'{ROW_SET_MAX, 32'h0, 32'hFFFF, EXP_PREDICTED},
		'{ROW_CHECK, 32'h0102_0304, 32'd9, EXP_PREDICTED},
		'{ROW_CHECK, 32'h0102_0304, 32'd10, EXP_PREDICTED}
	};

	// settings walked by the random part, extremes included
	logic [COUNT_W-1:0] phase_max [PHASES] = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd7, 16'd60};
	logic [TIME_W-1:0] phase_window [PHASES] =
		'{32'd20, 32'd1000, 32'hFFFF_FFFF, 32'd0, 32'd200, 32'd60000};

	// judge one request against the shadow table and update it
	function automatic bit judge_request(bit cmd, logic [ADDR_W-1:0] client,
		logic [TIME_W-1:0] stamp);
		int slot;
		bit found;
		logic [TIME_W-1:0] age;
		if (cmd == CMD_CLEAR) begin
			for (int i = 0; i < CLIENT_SLOTS; i++) begin
				slot_client[i] = '0;
				slot_opened[i] = '0;
				slot_hits[i] = '0;
			end
			return 1'b0;
		end
		// first in-use slot holding this client
		found = 1'b0;
		slot = 0;
		for (int i = 0; i < CLIENT_SLOTS; i++) begin
			if (!found && slot_opened[i] != '0 && slot_client[i] == client) begin
				slot = i;
				found = 1'b1;
			end
		end
		// otherwise the lowest free slot, or slot 0 when the table is full
		if (!found) begin
			slot = 0;
			for (int i = CLIENT_SLOTS - 1; i >= 0; i--) begin
				if (slot_opened[i] == '0) begin
					slot = i;
				end
			end
			slot_client[slot] = client;
			slot_hits[slot] = '0;
			slot_opened[slot] = stamp;
		end
		// wrapping age of the window decides a restart
		age = stamp - slot_opened[slot];
		if (age > lim_window) begin
			slot_hits[slot] = '0;
			slot_opened[slot] = stamp;
		end
		if (slot_hits[slot] >= lim_requests) begin
			return 1'b0;
		end
		slot_hits[slot] = slot_hits[slot] + 1'b1;
		return 1'b1;
	endfunction

	// offer one request beat; called and returning at a falling edge
	task automatic send_beat(bit cmd, logic [ADDR_W-1:0] client, logic [TIME_W-1:0] stamp,
		verdict_src_t verdict);
		bit predicted;
		// random gaps before the beat, unless a quiet stretch is on
		while (!no_idle && $urandom_range(0, 99) < 17) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid <= 1'b1;
		req.command <= cmd;
		req.client_address <= client;
		req.now_ms <= stamp;
		// beat is taken at the first rising edge with ready high
		do begin
			@(posedge clk);
		end while (!req.ready);
		predicted = judge_request(cmd, client, stamp);
		case (verdict)
			EXP_PREDICTED: pending_verdicts.push_back(predicted);
			EXP_ADMITTED:  pending_verdicts.push_back(1'b1);
			default:       pending_verdicts.push_back(1'b0);
		endcase
		@(negedge clk);
	endtask

	// stop offering, wait for every resp beat, then let the pipeline settle
	task automatic drain_responses();
		req.valid <= 1'b0;
		while (pending_verdicts.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write one limit register while the block is idle
	task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_REQUESTS) begin
			lim_requests = value[COUNT_W-1:0];
		end else begin
			lim_window = value[TIME_W-1:0];
		end
		@(negedge clk);
	endtask

	// free running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog: give up after a generous number of cycles
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_per_client_rate_limiter_core: done, errors");
		$finish;
	end

	// receiver: random stalls, quiet stretches and one long hold-off
	initial begin
		resp.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_pending) begin
				hold_pending = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				resp.ready <= 1'b0;
			end else if (no_idle) begin
				resp.ready <= 1'b1;
			end else begin
				resp.ready <= ($urandom_range(0, 99) >= 17);
			end
		end
	end

	// compare every resp beat with the oldest waiting verdict
	always @(posedge clk) begin
		if (arst_n && resp.valid && resp.ready) begin
			if (pending_verdicts.size() == 0) begin
				$error("allowed: expected none, got %0b", resp.allowed);
				mismatch_count++;
			end else begin
				if (resp.allowed !== pending_verdicts[0]) begin
					$error("allowed: expected %0b, got %0b", pending_verdicts[0],
						resp.allowed);
					mismatch_count++;
				end
				void'(pending_verdicts.pop_front());
			end
		end
	end

	// stimulus
	initial begin
		logic [ADDR_W-1:0] client_pool [POOL_MAX];
		logic [TIME_W-1:0] sim_ms;
		int pool_size;
		int roll;
		int step_roll;

		// every input known from time zero
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MAX_REQUESTS;
		cfg_data = '0;
		req.valid = 1'b0;
		req.command = CMD_CHECK;
		req.client_address = '0;
		req.now_ms = '0;
		no_idle = 1'b0;
		hold_pending = 1'b0;
		mismatch_count = 0;
		lim_requests = MAX_REQUESTS_RST;
		lim_window = WINDOW_LENGTH_RST;
		for (int i = 0; i < CLIENT_SLOTS; i++) begin
			slot_client[i] = '0;
			slot_opened[i] = '0;
			slot_hits[i] = '0;
		end

		// reset asserted from time zero, released on a falling edge
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed part: walk the table
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			case (directed_rows[r].kind)
				ROW_CHECK: begin
					send_beat(CMD_CHECK, directed_rows[r].client, directed_rows[r].stamp,
						directed_rows[r].verdict);
				end
				ROW_CLEAR: begin
					send_beat(CMD_CLEAR, directed_rows[r].client, directed_rows[r].stamp,
						directed_rows[r].verdict);
				end
				ROW_SET_MAX: begin
					drain_responses();
					write_reg(CFG_MAX_REQUESTS, directed_rows[r].stamp);
				end
				default: begin
					drain_responses();
					write_reg(CFG_WINDOW_LENGTH, directed_rows[r].stamp);
				end
			endcase
		end

		// random part: one phase per limit setting
		for (int p = 0; p < PHASES; p++) begin
			drain_responses();
			write_reg(CFG_MAX_REQUESTS, CFG_W'(phase_max[p]));
			write_reg(CFG_WINDOW_LENGTH, phase_window[p]);
			// a pool of 4 to POOL_MAX clients against the table slots, so larger pools keep evicting
			pool_size = $urandom_range(4, POOL_MAX);
			foreach (client_pool[i]) client_pool[i] = $urandom();
			// one phase starts just short of the time wrap
			if (p == 3) begin
				sim_ms = 32'hFFFF_FFFF - $urandom_range(0, 400);
			end else begin
				sim_ms = $urandom();
			end
			// the second phase runs with no idling on either side
			no_idle = (p == 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long receiver hold-off while requests keep coming
				if (p == 2 && n == 20) begin
					hold_pending = 1'b1;
				end
				roll = $urandom_range(0, 99);
				if (roll < 3) begin
					send_beat(CMD_CLEAR, $urandom(), $urandom(), EXP_PREDICTED);
				end else if (roll < 18) begin
					// noise: any client at any time
					send_beat(CMD_CHECK, $urandom(), $urandom(), EXP_PREDICTED);
				end else begin
					// known clients with time moving forward, mostly in small steps
					step_roll = $urandom_range(0, 99);
					if (step_roll < 90) begin
						sim_ms = sim_ms + $urandom_range(0, 6);
					end else if (step_roll < 98) begin
						sim_ms = sim_ms + $urandom_range(0, 2000);
					end else begin
						sim_ms = sim_ms + $urandom();
					end
					send_beat(CMD_CHECK, client_pool[$urandom_range(0, pool_size - 1)],
						sim_ms, EXP_PREDICTED);
				end
			end
		end

		// wait out every resp beat, then report
		drain_responses();
		if (mismatch_count == 0) begin
			$display("tb_per_client_rate_limiter_core: done, clean");
		end else begin
			$display("tb_per_client_rate_limiter_core: done, errors");
		end
		$finish;
	end

endmodule
